>>> src/spk_pkg.sv
// shared types and constants for the speck64/128 encryption pipeline
package spk_pkg;

    localparam int ROUNDS = 27;
    localparam int WORD_W = 32;
    localparam int BLOCK_W = 2 * WORD_W;
    localparam int RIDX_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int ROT_R = 8;
    localparam int ROT_L = 3;

    // configuration register indexes
    localparam logic REG_KEY_LOW = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [RIDX_W-1:0] ridx_t;

    // data words and key schedule state carried through each stage
    typedef struct packed {
        word_t x;
        word_t y;
        word_t k;
        word_t l0;
        word_t l1;
        word_t l2;
    } state_t;

    function automatic word_t rotr(input word_t v, input int n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic word_t rotl(input word_t v, input int n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

>>> src/speck64_128_encrypt.sv
// speck64/128 encryption top level: key registers and unrolled round pipeline
//
// encrypts one 64-bit word per clock with speck64/128 (27 rounds). a word is
// taken at any rising edge with start high; busy is always low since the
// unrolled pipeline takes a new word every cycle. each ciphertext word
// appears on block_out for exactly one cycle with done high, after one
// register stage per round (the first loaded on the edge that took its
// plaintext), in the same order as the inputs. the receiver cannot stall
// the pipeline, so done words must be captured as they come. the 128-bit
// key is loaded through wr_en / wr_index / wr_data (index 0 key_low,
// index 1 key_high) and must only change while no word is in flight;
// both halves reset to zero. round keys are derived on the fly, the key
// schedule travelling down the pipeline next to the data.
module speck64_128_encrypt (
    input  logic                          clk,
    input  logic                          rst_n,
    // command side
    input  logic                          start,
    output logic                          busy,
    input  logic [spk_pkg::BLOCK_W-1:0]   block_in,
    // result side
    output logic                          done,
    output logic [spk_pkg::BLOCK_W-1:0]   block_out,
    // configuration write port
    input  logic                          wr_en,
    input  logic                          wr_index,
    input  logic [spk_pkg::BLOCK_W-1:0]   wr_data
);

    logic [spk_pkg::BLOCK_W-1:0] key_low_reg;
    logic [spk_pkg::BLOCK_W-1:0] key_high_reg;

    // stage 0 is the entry point, stage ROUNDS the final round output
    logic            stage_valid [0:spk_pkg::ROUNDS];
    spk_pkg::state_t stage_state [0:spk_pkg::ROUNDS];

    // key registers: the user must write them only while the pipeline is empty; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                spk_pkg::REG_KEY_LOW:  key_low_reg  <= wr_data;
                spk_pkg::REG_KEY_HIGH: key_high_reg <= wr_data;
                default:               ;
            endcase
        end
    end

    // never stalls
    assign busy = 1'b0;

    // load plaintext and initial key schedule into the entry stage
    always_comb
    begin
        stage_valid[0]    = start && !busy;
        stage_state[0].x  = block_in[spk_pkg::WORD_W-1:0];
        stage_state[0].y  = block_in[spk_pkg::BLOCK_W-1:spk_pkg::WORD_W];
        stage_state[0].k  = key_low_reg[spk_pkg::WORD_W-1:0];
        stage_state[0].l0 = key_low_reg[spk_pkg::BLOCK_W-1:spk_pkg::WORD_W];
        stage_state[0].l1 = key_high_reg[spk_pkg::WORD_W-1:0];
        stage_state[0].l2 = key_high_reg[spk_pkg::BLOCK_W-1:spk_pkg::WORD_W];
    end

    // one register stage per round
    for (genvar r = 0; r < spk_pkg::ROUNDS; r++)
    begin : g_round
        spk_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stage_valid[r]),
            .round_idx (spk_pkg::ridx_t'(r)),
            .state_in  (stage_state[r]),
            .valid_out (stage_valid[r+1]),
            .state_out (stage_state[r+1])
        );
    end

    // last stage register drives the result word directly
    assign done      = stage_valid[spk_pkg::ROUNDS];
    assign block_out = {stage_state[spk_pkg::ROUNDS].y, stage_state[spk_pkg::ROUNDS].x};

endmodule

>>> src/spk_round.sv
// one registered round of the cipher with its key schedule step
module spk_round (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  spk_pkg::ridx_t  round_idx,
    input  spk_pkg::state_t state_in,
    output logic            valid_out,
    output spk_pkg::state_t state_out
);

    logic            valid_reg;
    spk_pkg::state_t state_reg;
    spk_pkg::state_t state_next;
    spk_pkg::word_t  nx;
    spk_pkg::word_t  nl;

    always_comb
    begin
        nx = (spk_pkg::rotr(state_in.x, spk_pkg::ROT_R) + state_in.y) ^ state_in.k;
        nl = (spk_pkg::rotr(state_in.l0, spk_pkg::ROT_R) + state_in.k)
             ^ spk_pkg::word_t'(round_idx);
        state_next.x  = nx;
        state_next.y  = spk_pkg::rotl(state_in.y, spk_pkg::ROT_L) ^ nx;
        state_next.k  = spk_pkg::rotl(state_in.k, spk_pkg::ROT_L) ^ nl;
        state_next.l0 = state_in.l1;
        state_next.l1 = state_in.l2;
        state_next.l2 = nl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the speck64/128 encryption pipeline
`timescale 1ns / 1ps

module tb;

    // ------------------------------------------------------------------
    // ciphertext scoreboard
    // keeps its own copy of the two key registers and a queue of the
    // ciphertext words still owed by the pipeline, oldest first
    // ------------------------------------------------------------------
    class cipher_scoreboard;
        logic [spk_pkg::BLOCK_W-1:0] key_lo;
        logic [spk_pkg::BLOCK_W-1:0] key_hi;
        logic [spk_pkg::BLOCK_W-1:0] cipher_q[$];
        int                          errors;

        function new();
            key_lo = '0;
            key_hi = '0;
            errors = 0;
        endfunction

        function void load_key(input logic idx, input logic [spk_pkg::BLOCK_W-1:0] value);
            if (idx == spk_pkg::REG_KEY_LOW)
                key_lo = value;
            else
                key_hi = value;
        endfunction

        // all 27 rounds with the key schedule run alongside the data
        // ror 8 and rol 3 are written out as slice swaps
        function logic [spk_pkg::BLOCK_W-1:0] encipher(
            input logic [spk_pkg::BLOCK_W-1:0] plain);
            spk_pkg::word_t x;
            spk_pkg::word_t y;
            spk_pkg::word_t rk;
            spk_pkg::word_t ring_a;
            spk_pkg::word_t ring_b;
            spk_pkg::word_t ring_c;
            spk_pkg::word_t fresh;
            int             r;
            x      = plain[31:0];
            y      = plain[63:32];
            rk     = key_lo[31:0];
            ring_a = key_lo[63:32];
            ring_b = key_hi[31:0];
            ring_c = key_hi[63:32];
            for (r = 0; r < spk_pkg::ROUNDS; r++)
            begin
                x      = ({x[7:0], x[31:8]} + y) ^ rk;
                y      = {y[28:0], y[31:29]} ^ x;
                fresh  = ({ring_a[7:0], ring_a[31:8]} + rk) ^ spk_pkg::word_t'(r);
                rk     = {rk[28:0], rk[31:29]} ^ fresh;
                ring_a = ring_b;
                ring_b = ring_c;
                ring_c = fresh;
            end
            return {y, x};
        endfunction

        function void note_plain(input logic [spk_pkg::BLOCK_W-1:0] plain);
            cipher_q.push_back(encipher(plain));
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_cipher(input logic [spk_pkg::BLOCK_W-1:0] got);
            logic [spk_pkg::BLOCK_W-1:0] want;
            if (cipher_q.size() == 0)
                report($sformatf("ciphertext word %h with none outstanding", got));
            else
            begin
                want = cipher_q.pop_front();
                if (got !== want)
                    report($sformatf("block_out %h, predicted %h", got, want));
            end
        endtask
    endclass

    // ------------------------------------------------------------------
    // signals and the block under test
    // ------------------------------------------------------------------
    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [spk_pkg::BLOCK_W-1:0] block_in;
    logic                        done;
    logic [spk_pkg::BLOCK_W-1:0] block_out;
    logic                        wr_en;
    logic                        wr_index;
    logic [spk_pkg::BLOCK_W-1:0] wr_data;

    cipher_scoreboard sb = new();

    speck64_128_encrypt uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .block_in  (block_in),
        .done      (done),
        .block_out (block_out),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop in case the pipeline hangs or drops words
    initial
    begin
        #2000000;
        $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // monitor: everything is sampled on the rising edge, while the
    // values of the cycle that just ended are still on the wires.
    // the result is checked before the new word is noted so that a
    // word accepted on this edge can never pair with an output
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_cipher(block_out);
            if (start && !busy)
                sb.note_plain(block_in);
            if (wr_en)
                sb.load_key(wr_index, wr_data);
        end
    end

    // ------------------------------------------------------------------
    // drivers: all called and returning on a falling edge, so every
    // input changes half a cycle away from the sampling edge
    // ------------------------------------------------------------------

    // offer one plaintext word, with a random run of idle cycles first
    // start is set once per step, so back-to-back words keep it high
    task automatic send_plain(input logic [spk_pkg::BLOCK_W-1:0] plain, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start    <= 1'b0;
            block_in <= {$urandom, $urandom};
            @(negedge clk);
        end
        start    <= 1'b1;
        block_in <= plain;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // hold the sender off until the pipeline has handed back every word
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.cipher_q.size() != 0);
    endtask

    // load the low then the high key half on consecutive edges, pipeline empty
    task automatic load_keys(input logic [spk_pkg::BLOCK_W-1:0] lo,
                             input logic [spk_pkg::BLOCK_W-1:0] hi);
        wr_en    <= 1'b1;
        wr_index <= spk_pkg::REG_KEY_LOW;
        wr_data  <= lo;
        @(negedge clk);
        wr_index <= spk_pkg::REG_KEY_HIGH;
        wr_data  <= hi;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    // plaintext mix: corner patterns in six picks out of ten, uniform random words in the rest
    function automatic logic [spk_pkg::BLOCK_W-1:0] pick_plain();
        unique case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return {{$urandom}, 32'hffff_ffff};
            3:       return {32'h0000_0000, {$urandom}};
            4:       return {{spk_pkg::BLOCK_W-1{1'b0}}, 1'b1}
                            << $urandom_range(spk_pkg::BLOCK_W - 1);
            5:       return ~({{spk_pkg::BLOCK_W-1{1'b0}}, 1'b1}
                              << $urandom_range(spk_pkg::BLOCK_W - 1));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one key setting: change the key on an empty pipeline, then a run of
    // random words, with a full drain halfway through
    task automatic run_phase(input logic [spk_pkg::BLOCK_W-1:0] lo,
                             input logic [spk_pkg::BLOCK_W-1:0] hi,
                             input int count, input int idle_pct);
        int i;
        drain();
        load_keys(lo, hi);
        for (i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain();
            send_plain(pick_plain(), idle_pct);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        start    = 1'b0;
        block_in = '0;
        wr_en    = 1'b0;
        wr_index = spk_pkg::REG_KEY_LOW;
        wr_data  = '0;
        rst_n    = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // key never written: both halves still hold the all-zero reset value
        send_plain('0, 0);
        send_plain('1, 0);
        send_plain(64'h0000_0000_0000_0001, 0);
        send_plain(64'h8000_0000_0000_0000, 0);
        send_plain(64'h0000_0000_ffff_ffff, 0);
        send_plain(64'hffff_ffff_0000_0000, 0);
        send_plain(64'h5555_5555_5555_5555, 0);
        send_plain(64'haaaa_aaaa_aaaa_aaaa, 0);
        send_plain(64'h3b72_6574_7475_432d, 0);

        // published test key with its test plaintext, words in the block order
        drain();
        load_keys(64'h0b0a_0908_0302_0100, 64'h1b1a_1918_1312_1110);
        send_plain(64'h3b72_6574_7475_432d, 0);
        send_plain('0, 0);
        send_plain('1, 0);

        // all-ones key
        drain();
        load_keys('1, '1);
        send_plain('0, 0);
        send_plain('1, 0);
        send_plain(64'h0000_0001_8000_0000, 0);

        // random words: light sender gaps, then heavy gaps, then none
        run_phase('1, '1, 192, 21);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 192, 21);
        run_phase(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 192, 88);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 192, 88);
        run_phase('0, '0, 192, 0);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 192, 0);

        // let the pipeline empty, then a margin beyond its depth for strays
        drain();
        repeat (spk_pkg::ROUNDS + 13) @(negedge clk);
        if (sb.cipher_q.size() != 0)
            sb.report($sformatf("%0d ciphertext words never came", sb.cipher_q.size()));

        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
